@@ sv/xoshiro256pp_generator_macros.svh @@
// ----------------------------------------------------------------------------
// xoshiro256pp_generator_macros
// assertion shorthands used by the checker file xsr_checker.sv
// ----------------------------------------------------------------------------
`ifndef XOSHIRO256PP_GENERATOR_MACROS_SVH
`define XOSHIRO256PP_GENERATOR_MACROS_SVH

// same-cycle implication on the checker clock, quiet during reset
`define XSR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xsr check failed");

// next-cycle implication on the checker clock, quiet during reset
`define XSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xsr check failed");

`endif

@@ sv/xsr_pkg.sv @@
// ----------------------------------------------------------------------------
// xsr_pkg
// types and constants of the xoshiro256++ generator and its seed expander
// ----------------------------------------------------------------------------
package xsr_pkg;

    typedef logic [63:0] word_t;
    typedef logic [3:0][63:0] word_set_t;

    localparam word_t SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam word_t SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
    localparam word_t SM_MUL2  = 64'h94d0_49bb_1331_11eb;

    localparam int unsigned ROT_OUT = 23;
    localparam int unsigned ROT_S3  = 45;
    localparam int unsigned SHL_T   = 17;

    // handshake between the top level and the seed expander
    typedef struct packed {
        logic start;
        logic done;
    } seed_ctl_t;

    function automatic word_t rot_left(input word_t v, input int unsigned r);
        word_t res;
        res = (v << r) | (v >> (64 - r));
        return res;
    endfunction

endpackage

@@ sv/xsr_draw_if.sv @@
// ----------------------------------------------------------------------------
// xsr_draw_if
// draw request channel: valid, ready and the restart flag
// ----------------------------------------------------------------------------
interface xsr_draw_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

@@ sv/xsr_value_if.sv @@
// ----------------------------------------------------------------------------
// xsr_value_if
// result channel: valid, ready and the 64-bit random word
// ----------------------------------------------------------------------------
interface xsr_value_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);
endinterface

@@ sv/xoshiro256pp_generator.sv @@
// ----------------------------------------------------------------------------
// xoshiro256pp_generator
// xoshiro256++ draw engine with splitmix64 seeding from a seed register
// ----------------------------------------------------------------------------
//  channel   dir   payload        word accepted when
//  draw      in    restart        draw.valid && draw.ready
//  result    out   random_value   result.valid && result.ready
//  cfg       in    cfg_wr_data    cfg_wr_en (seed register)
//
//  a plain draw steps through accept, the sum of words 0 and 3, then the
//  output add, rotate and state step into the output register
//  a reseeding draw first runs four splitmix64 outputs, each two 64-bit
//  products built from three 32x32 passes of the one shared multiplier,
//  and then loads the new words
//  one draw is in flight at a time; the finishing step waits while the
//  previous word still sits unread in the output register
//  reset clears control and the seeded flag; the first draw always reseeds
// ----------------------------------------------------------------------------
module xoshiro256pp_generator (
    input  logic               clk,
    input  logic               rst_n,
    xsr_draw_if.sink           draw,
    xsr_value_if.source        result,
    input  logic               cfg_wr_en,
    input  xsr_pkg::word_t     cfg_wr_data
);
    import xsr_pkg::*;

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEED = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;
    localparam logic [1:0] S_FORM = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       seeded_reg;
    word_t      seed_reg;
    word_set_t  gen_reg;
    word_set_t  gen_step;
    word_t      sum_reg;
    word_t      out_data_reg;
    logic       out_valid_reg;
    logic       draw_fire;
    logic       out_free;
    seed_ctl_t  seed_ctl;
    word_set_t  seed_words;
    word_t      t_shift;
    word_t      w0_x;
    word_t      w1_x;
    word_t      w2_x;
    word_t      w3_x;

    assign draw_fire = draw.valid && draw.ready;
    // output register is free when empty or being emptied this cycle
    assign out_free  = !out_valid_reg || result.ready;

    assign seed_ctl.start = (state_reg == S_IDLE) && draw_fire
                            && (draw.restart || !seeded_reg);

    xsr_seeder u_seeder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seed_ctl.start),
        .seed  (seed_reg),
        .done  (seed_ctl.done),
        .words (seed_words)
    );

    // one xoshiro256++ state step
    always_comb
    begin
        t_shift     = gen_reg[1] << SHL_T;
        w2_x        = gen_reg[2] ^ gen_reg[0];
        w3_x        = gen_reg[3] ^ gen_reg[1];
        w1_x        = gen_reg[1] ^ w2_x;
        w0_x        = gen_reg[0] ^ w3_x;
        gen_step[0] = w0_x;
        gen_step[1] = w1_x;
        gen_step[2] = w2_x ^ t_shift;
        gen_step[3] = rot_left(w3_x, ROT_S3);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (draw_fire)
                begin
                    state_next = seed_ctl.start ? S_SEED : S_SUM;
                end
            end
            S_SEED:
            begin
                if (seed_ctl.done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_FORM;
            end
            S_FORM:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            seed_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
            if (state_reg == S_SEED && seed_ctl.done)
            begin
                seeded_reg <= 1'b1;
            end
            if (state_reg == S_FORM && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // state words and datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SEED && seed_ctl.done)
        begin
            gen_reg <= seed_words;
        end
        else if (state_reg == S_FORM && out_free)
        begin
            gen_reg <= gen_step;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= gen_reg[0] + gen_reg[3];
        end
        if (state_reg == S_FORM && out_free)
        begin
            out_data_reg <= rot_left(sum_reg, ROT_OUT) + gen_reg[0];
        end
    end

    assign draw.ready          = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.random_value = out_data_reg;

endmodule

@@ sv/xsr_mul64.sv @@
// ----------------------------------------------------------------------------
// xsr_mul64
// iterative 64x64 multiplier, low half only, one 32x32 partial product a cycle
// ----------------------------------------------------------------------------
module xsr_mul64 (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  xsr_pkg::word_t a,
    input  xsr_pkg::word_t b,
    output logic           done,
    output xsr_pkg::word_t product
);
    import xsr_pkg::*;

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    word_t       a_reg;
    word_t       b_reg;
    word_t       acc_reg;
    word_t       acc_next;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] part;

    always_comb
    begin
        op_x = a_reg[31:0];
        op_y = b_reg[31:0];
        unique case (step_reg)
            STEP_LL:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            STEP_LH:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            STEP_HL:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
            default:
            begin
                op_x = '0;
                op_y = '0;
            end
        endcase
        part = 64'(op_x) * 64'(op_y);
        // cross terms only reach the upper half
        if (step_reg == STEP_LL)
        begin
            acc_next = part;
        end
        else
        begin
            acc_next = acc_reg + {part[31:0], 32'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_LL;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_HL)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= STEP_LL;
                end
                else
                begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ sv/xsr_seeder.sv @@
// ----------------------------------------------------------------------------
// xsr_seeder
// splitmix64 sequencer: four outputs from the seed through the shared multiplier
// ----------------------------------------------------------------------------
module xsr_seeder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  xsr_pkg::word_t     seed,
    output logic               done,
    output xsr_pkg::word_set_t words
);
    import xsr_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ADD  = 2'd1;
    localparam logic [1:0] PH_MUL1 = 2'd2;
    localparam logic [1:0] PH_MUL2 = 2'd3;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [1:0] idx_reg;
    logic       done_reg;
    word_t      ctr_reg;
    word_t      ctr_next;
    word_set_t  words_reg;
    logic       mul_start;
    word_t      mul_a;
    word_t      mul_b;
    logic       mul_done;
    word_t      mul_prod;

    xsr_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb
    begin
        ctr_next   = ctr_reg + SM_GAMMA;
        phase_next = phase_reg;
        mul_start  = 1'b0;
        mul_a      = ctr_next ^ (ctr_next >> 30);
        mul_b      = SM_MUL1;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_ADD;
                end
            end
            PH_ADD:
            begin
                mul_start  = 1'b1;
                phase_next = PH_MUL1;
            end
            PH_MUL1:
            begin
                mul_a = mul_prod ^ (mul_prod >> 27);
                mul_b = SM_MUL2;
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    phase_next = PH_MUL2;
                end
            end
            PH_MUL2:
            begin
                if (mul_done)
                begin
                    phase_next = (idx_reg == 2'd3) ? PH_IDLE : PH_ADD;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= 1'b0;
            if (phase_reg == PH_IDLE && start)
            begin
                idx_reg <= 2'd0;
            end
            else if (phase_reg == PH_MUL2 && mul_done)
            begin
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            ctr_reg <= seed;
        end
        else if (phase_reg == PH_ADD)
        begin
            ctr_reg <= ctr_next;
        end
        if (phase_reg == PH_MUL2 && mul_done)
        begin
            words_reg[idx_reg] <= mul_prod ^ (mul_prod >> 31);
        end
    end

    assign done  = done_reg;
    assign words = words_reg;

endmodule

@@ sv/xsr_checker.sv @@
// ----------------------------------------------------------------------------
// xsr_checker
// port-level checks of the generator, bound to the top level
// ----------------------------------------------------------------------------
`include "xoshiro256pp_generator_macros.svh"

module xsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        draw_valid,
    input logic        draw_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [63:0] result_value
);
    logic draw_fire;

    assign draw_fire = draw_valid && draw_ready;

    // stalled word holds
    `XSR_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(result_value))

    // a draw keeps the engine busy, with draw_ready low, through the sum and form steps
    `XSR_ASSERT_NEXT(a_busy, draw_fire, !draw_ready ##1 !draw_ready)

    // no word can appear in the cycle right after a draw is taken
    `XSR_ASSERT_NEXT(a_no_early, draw_fire, !$rose(result_valid))

    // ready rises again only with the new word valid in the result register
    `XSR_ASSERT_IMP(a_ready_rise, $rose(draw_ready), result_valid)

endmodule

bind xoshiro256pp_generator xsr_checker u_xsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .draw_valid   (draw.valid),
    .draw_ready   (draw.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_value (result.random_value)
);
